FILE: rtl/tex_catcode_tokenizer_macros.svh
// Assertion macros for the tokenizer scanner, tct_scan.
// Needs signals clk and arst_n in the including scope.
`ifndef TEX_CATCODE_TOKENIZER_MACROS_SVH
`define TEX_CATCODE_TOKENIZER_MACROS_SVH

// Same-cycle implication, off while in reset.
`define TCT_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, off while in reset.
`define TCT_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/tct_pkg.sv
// Shared types, constants and category lookup for the catcode tokenizer.
// No dependencies.
package tct_pkg;

	localparam int TABLE_ENTRIES = 256;
	localparam int TBL_AW        = $clog2(TABLE_ENTRIES);
	localparam int LINE_BITS     = 24;
	localparam int CHAR_W        = 21;
	localparam int CAT_W         = 4;
	localparam int LINE_FIELD_W  = 24;

	typedef enum logic [1:0] {
		REQ_CHAR     = 2'd0,
		REQ_OVERRIDE = 2'd1,
		REQ_SET      = 2'd2,
		REQ_END      = 2'd3
	} req_e_t;

	// TeX category numbering
	localparam logic [CAT_W-1:0] CAT_ESCAPE  = 4'd0;
	localparam logic [CAT_W-1:0] CAT_BGROUP  = 4'd1;
	localparam logic [CAT_W-1:0] CAT_EGROUP  = 4'd2;
	localparam logic [CAT_W-1:0] CAT_MATH    = 4'd3;
	localparam logic [CAT_W-1:0] CAT_ALIGN   = 4'd4;
	localparam logic [CAT_W-1:0] CAT_NEWLINE = 4'd5;
	localparam logic [CAT_W-1:0] CAT_PARAM   = 4'd6;
	localparam logic [CAT_W-1:0] CAT_SUPER   = 4'd7;
	localparam logic [CAT_W-1:0] CAT_SUB     = 4'd8;
	localparam logic [CAT_W-1:0] CAT_IGNORED = 4'd9;
	localparam logic [CAT_W-1:0] CAT_SPACE   = 4'd10;
	localparam logic [CAT_W-1:0] CAT_LETTER  = 4'd11;
	localparam logic [CAT_W-1:0] CAT_OTHER   = 4'd12;
	localparam logic [CAT_W-1:0] CAT_ACTIVE  = 4'd13;
	localparam logic [CAT_W-1:0] CAT_COMMENT = 4'd14;

	localparam logic [CHAR_W-1:0] CH_LF = 21'h00000A;
	localparam logic [CHAR_W-1:0] CH_CR = 21'h00000D;

	// One request held in the lookup stage, with its category resolved.
	typedef struct packed {
		req_e_t              req;
		logic [CHAR_W-1:0]   chr;
		logic [CAT_W-1:0]    cat;
	} tct_item_t;

	// Built-in sets: 0 normal, 1 verbatim.
	function automatic logic [CAT_W-1:0] builtin_class(input logic [7:0] c,
			input logic verb);
		logic [CAT_W-1:0] k;
		if ((c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) || c == 8'h40) begin
			k = CAT_LETTER;
		end else if (verb) begin
			k = CAT_OTHER;
		end else begin
			case (c)
				8'h5C:   k = CAT_ESCAPE;
				8'h7B:   k = CAT_BGROUP;
				8'h7D:   k = CAT_EGROUP;
				8'h24:   k = CAT_MATH;
				8'h26:   k = CAT_ALIGN;
				8'h0A:   k = CAT_NEWLINE;
				8'h0D:   k = CAT_NEWLINE;
				8'h23:   k = CAT_PARAM;
				8'h5E:   k = CAT_SUPER;
				8'h5F:   k = CAT_SUB;
				8'h7F:   k = CAT_IGNORED;
				8'h20:   k = CAT_SPACE;
				8'h09:   k = CAT_SPACE;
				8'h7E:   k = CAT_ACTIVE;
				8'h25:   k = CAT_COMMENT;
				default: k = CAT_OTHER;
			endcase
		end
		return k;
	endfunction

	// Override wins; code points of 256 and up are always other.
	function automatic logic [CAT_W-1:0] char_class(input logic [CHAR_W-1:0] c,
			input logic ovr_hit, input logic [CAT_W-1:0] ovr_cat, input logic verb);
		logic [CAT_W-1:0] k;
		if (c[CHAR_W-1:8] != '0) begin
			k = CAT_OTHER;
		end else if (ovr_hit) begin
			k = ovr_cat;
		end else begin
			k = builtin_class(c[7:0], verb);
		end
		return k;
	endfunction

endpackage

FILE: rtl/tex_catcode_tokenizer.sv
// Catcode tokenizer: one request accepted per cycle while the result side keeps up.
// Throughput one request per cycle unless m_tready stalls; one RAM read per character.
// Accept edge loads lookup stage; scanner take loads the result register if it emits.
// Reset: scanner idle, line count 0, normal set, all overrides invalid (valid bits
// cleared at once, no clearing pass); override RAM contents are left undefined.
module tex_catcode_tokenizer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,  // char_code[20:0], cat_value[24:21], zero fill
	input  logic [1:0]  s_tuser,  // req_type[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [55:0] m_tdata,  // out_char[20:0], out_cat[24:21], line_count[48:25]
	output logic [3:0]  m_tuser,  // new_token, char_valid, input_ended, escape_error
	output logic        m_tlast
);
	import tct_pkg::*;

	logic                    in_fire;
	logic                    vld_s1;
	logic                    take;
	tct_item_t               item_s1;
	logic [CHAR_W-1:0]       o_char;
	logic [CAT_W-1:0]        o_cat;
	logic [LINE_FIELD_W-1:0] o_lines;
	logic                    o_new, o_charv, o_ended, o_err;

	// Lookup stage drains whenever the scanner takes its request, so a new
	// request enters every cycle while the result side keeps up.
	assign s_tready = !vld_s1 || take;
	assign in_fire  = s_tvalid && s_tready;

	// Override table and lookup stage: overrides and set selects act here.
	tct_table u_table (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_fire (in_fire),
		.in_req  (req_e_t'(s_tuser)),
		.in_char (s_tdata[CHAR_W-1:0]),
		.in_val  (s_tdata[CHAR_W+CAT_W-1:CHAR_W]),
		.take    (take),
		.vld_s1  (vld_s1),
		.item_s1 (item_s1)
	);

	// Scanner: token grouping, newline folding, comment handling, line count.
	tct_scan u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.item_vld  (vld_s1),
		.item      (item_s1),
		.take      (take),
		.out_ready (m_tready),
		.out_vld   (m_tvalid),
		.out_char  (o_char),
		.out_cat   (o_cat),
		.out_lines (o_lines),
		.out_new   (o_new),
		.out_charv (o_charv),
		.out_ended (o_ended),
		.out_err   (o_err)
	);

	assign m_tdata = {7'b0, o_lines, o_cat, o_char};
	assign m_tuser = {o_err, o_ended, o_charv, o_new};
	// every request gives at most one result, so each result ends its request
	assign m_tlast = 1'b1;
endmodule

FILE: rtl/tct_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module tct_ram #(
	parameter int WIDTH = 4,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

FILE: rtl/tct_table.sv
// Category table: override RAM, override valid bits, active set, lookup stage.
// Depends on tct_pkg and tct_ram.
module tct_table (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_fire,
	input  tct_pkg::req_e_t               in_req,
	input  logic [tct_pkg::CHAR_W-1:0]    in_char,
	input  logic [tct_pkg::CAT_W-1:0]     in_val,
	input  logic                          take,
	output logic                          vld_s1,
	output tct_pkg::tct_item_t            item_s1
);
	import tct_pkg::*;

	logic [TABLE_ENTRIES-1:0] ovr_valid_q;
	logic                     active_set_q;
	req_e_t                   req_s1;
	logic [CHAR_W-1:0]        chr_s1;
	logic                     ovrv_s1;
	logic                     set_s1;
	logic [CAT_W-1:0]         ram_rdata;
	logic                     in_range;
	logic [TBL_AW-1:0]        idx;
	logic                     ram_we;
	logic                     ram_re;
	logic                     set_change;

	assign in_range   = in_char < CHAR_W'(TABLE_ENTRIES);
	assign idx        = in_char[TBL_AW-1:0];
	assign ram_we     = in_fire && in_req == REQ_OVERRIDE && in_range;
	assign ram_re     = in_fire && in_req == REQ_CHAR;
	assign set_change = in_fire && in_req == REQ_SET && in_val[CAT_W-1:1] == '0
		&& in_val[0] != active_set_q;

	// Writes land at the accept edge, so the next request already sees them.
	tct_ram #(.WIDTH(CAT_W), .DEPTH(TABLE_ENTRIES)) u_ovr_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (idx),
		.wdata (in_val),
		.re    (ram_re),
		.raddr (idx),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovr_valid_q  <= '0;
			active_set_q <= 1'b0;
		end else if (set_change) begin
			ovr_valid_q  <= '0;
			active_set_q <= in_val[0];
		end else if (ram_we) begin
			ovr_valid_q[idx] <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_fire) begin
			vld_s1 <= 1'b1;
		end else if (take) begin
			vld_s1 <= 1'b0;
		end
	end

	// Table state is sampled with the request, so later writes cannot touch it.
	always_ff @(posedge clk) begin
		if (in_fire) begin
			req_s1  <= in_req;
			chr_s1  <= in_char;
			ovrv_s1 <= in_range && ovr_valid_q[idx];
			set_s1  <= active_set_q;
		end
	end

	always_comb begin
		item_s1.req = req_s1;
		item_s1.chr = chr_s1;
		item_s1.cat = char_class(chr_s1, ovrv_s1, ram_rdata, set_s1);
	end
endmodule

FILE: rtl/tct_scan.sv
// Scanner state machine, line counter and result register.
// Depends on tct_pkg and tex_catcode_tokenizer_macros.svh.
module tct_scan (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              item_vld,
	input  tct_pkg::tct_item_t                item,
	output logic                              take,
	input  logic                              out_ready,
	output logic                              out_vld,
	output logic [tct_pkg::CHAR_W-1:0]        out_char,
	output logic [tct_pkg::CAT_W-1:0]         out_cat,
	output logic [tct_pkg::LINE_FIELD_W-1:0]  out_lines,
	output logic                              out_new,
	output logic                              out_charv,
	output logic                              out_ended,
	output logic                              out_err
);
	import tct_pkg::*;
	`include "tex_catcode_tokenizer_macros.svh"

	localparam int CW = (LINE_BITS > LINE_FIELD_W) ? LINE_BITS : LINE_FIELD_W;

	typedef enum logic [5:0] {
		M_IDLE     = 6'b000001,
		M_SPACE    = 6'b000010,
		M_NEWLINE  = 6'b000100,
		M_COMMENT  = 6'b001000,
		M_ESC1     = 6'b010000,
		M_ESCW     = 6'b100000
	} mode_t;

	mode_t                   mode_q, mode_n;
	logic                    pcr_q, pcr_n;
	logic [LINE_BITS-1:0]    lines_q, lines_n;
	logic                    out_vld_q;
	logic [CHAR_W-1:0]       out_char_q, o_char, nl_char;
	logic [CAT_W-1:0]        out_cat_q, o_cat;
	logic [LINE_FIELD_W-1:0] out_lines_q, lines_fld;
	logic                    out_new_q, out_charv_q, out_ended_q, out_err_q;
	logic                    o_nt, o_cv, o_end, o_err;
	logic                    emit, inc, start, is_cr;
	logic [CW-1:0]           lines_wide;

	assign take    = item_vld && (!out_vld_q || out_ready);
	assign is_cr   = item.chr == CH_CR;
	assign nl_char = is_cr ? CH_LF : item.chr;

	always_comb begin
		mode_n = mode_q;
		pcr_n  = pcr_q;
		inc    = 1'b0;
		emit   = 1'b0;
		start  = 1'b0;
		o_char = item.chr;
		o_cat  = item.cat;
		o_nt   = 1'b0;
		o_cv   = 1'b1;
		o_end  = 1'b0;
		o_err  = 1'b0;
		unique case (item.req)
			REQ_CHAR: begin
				pcr_n = 1'b0;
				// LF right after a CR newline is swallowed
				if (!(pcr_q && item.chr == CH_LF)) begin
					unique case (mode_q)
						M_SPACE: begin
							if (item.cat == CAT_SPACE) begin
								emit = 1'b1;
							end else begin
								start = 1'b1;
							end
						end
						M_NEWLINE: begin
							if (item.cat == CAT_NEWLINE) begin
								emit   = 1'b1;
								inc    = 1'b1;
								o_char = nl_char;
								pcr_n  = is_cr;
							end else begin
								start = 1'b1;
							end
						end
						M_COMMENT: begin
							if (item.cat == CAT_NEWLINE) begin
								inc    = 1'b1;
								pcr_n  = is_cr;
								mode_n = M_IDLE;
							end else begin
								emit  = 1'b1;
								o_cat = CAT_COMMENT;
							end
						end
						M_ESC1: begin
							mode_n = (item.cat == CAT_LETTER) ? M_ESCW : M_IDLE;
							emit   = 1'b1;
							o_cat  = CAT_ESCAPE;
							o_nt   = 1'b1;
						end
						M_ESCW: begin
							if (item.cat == CAT_LETTER) begin
								emit  = 1'b1;
								o_cat = CAT_ESCAPE;
							end else begin
								start = 1'b1;
							end
						end
						default: begin
							start = 1'b1;
						end
					endcase
					if (start) begin
						mode_n = M_IDLE;
						o_nt   = 1'b1;
						case (item.cat)
							CAT_SPACE: begin
								mode_n = M_SPACE;
								emit   = 1'b1;
							end
							CAT_NEWLINE: begin
								mode_n = M_NEWLINE;
								emit   = 1'b1;
								inc    = 1'b1;
								o_char = nl_char;
								pcr_n  = is_cr;
							end
							CAT_COMMENT: begin
								mode_n = M_COMMENT;
								emit   = 1'b1;
								o_char = '0;
								o_cv   = 1'b0;
							end
							CAT_ESCAPE: begin
								mode_n = M_ESC1;
							end
							CAT_IGNORED: begin
							end
							default: begin
								emit = 1'b1;
							end
						endcase
					end
				end
			end
			REQ_END: begin
				emit   = 1'b1;
				o_char = '0;
				o_cat  = CAT_ESCAPE;
				o_cv   = 1'b0;
				o_end  = 1'b1;
				o_err  = mode_q == M_ESC1;
				inc    = mode_q == M_COMMENT;
				mode_n = M_IDLE;
				pcr_n  = 1'b0;
			end
			default: begin
			end
		endcase
	end

	// saturating line count, clamped again to the field width
	assign lines_n    = (inc && lines_q != '1) ? lines_q + 1'b1 : lines_q;
	assign lines_wide = CW'(lines_n);
	assign lines_fld  = (lines_wide > CW'({LINE_FIELD_W{1'b1}})) ? '1
		: lines_wide[LINE_FIELD_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= M_IDLE;
			pcr_q   <= 1'b0;
			lines_q <= '0;
		end else if (take) begin
			mode_q  <= mode_n;
			pcr_q   <= pcr_n;
			lines_q <= lines_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (take && emit) begin
			out_vld_q <= 1'b1;
		end else if (out_ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take && emit) begin
			out_char_q  <= o_char;
			out_cat_q   <= o_cat;
			out_lines_q <= lines_fld;
			out_new_q   <= o_nt;
			out_charv_q <= o_cv;
			out_ended_q <= o_end;
			out_err_q   <= o_err;
		end
	end

	assign out_vld   = out_vld_q;
	assign out_char  = out_char_q;
	assign out_cat   = out_cat_q;
	assign out_lines = out_lines_q;
	assign out_new   = out_new_q;
	assign out_charv = out_charv_q;
	assign out_ended = out_ended_q;
	assign out_err   = out_err_q;

	`TCT_ASSERT_NOW(a_pcr_mode, pcr_q, mode_q == M_NEWLINE || mode_q == M_IDLE,
		"pending CR outside newline run or idle")
	`TCT_ASSERT_NEXT(a_end_result, take && item.req == REQ_END,
		out_vld_q && out_ended_q, "end of input gave no result")
	`TCT_ASSERT_NEXT(a_lines_mono, 1'b1, lines_q >= $past(lines_q),
		"line counter went backwards")
	`TCT_ASSERT_NOW(a_marker, out_vld_q && !out_charv_q && !out_ended_q,
		out_cat_q == CAT_COMMENT && out_new_q, "bad comment start marker")
endmodule
